[design/assert_macros.svh]
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property, sampled on the rising clock edge and disabled while in reset.
`define UKCD_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("ukcd assertion failed");

// Same-cycle implication.
`define UKCD_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ukcd assertion failed");

// Next-cycle implication.
`define UKCD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ukcd assertion failed");

`endif

[design/ukcd_pkg.sv]
// Types, constants and keyword helpers for the keyword command decoder.
package ukcd_pkg;

  // Line buffer depth; one entry stays unused so a full line is LineCap-1 chars
  localparam int unsigned LineCap = 64;
  localparam int unsigned LenW    = $clog2(LineCap);

  typedef logic [LenW-1:0] len_t;
  typedef logic [7:0]      byte_t;
  typedef logic [2:0]      pos_t;    // keyword position, saturates at 7

  localparam byte_t ChrTab   = 8'h09;
  localparam byte_t ChrLf    = 8'h0A;
  localparam byte_t ChrCr    = 8'h0D;
  localparam byte_t ChrSpace = 8'h20;
  localparam byte_t ChrLowA  = 8'h61;
  localparam byte_t ChrLowZ  = 8'h7A;
  localparam byte_t CaseDiff = 8'h20;
  localparam byte_t ChrNone  = 8'hFF;

  typedef enum logic [2:0] {
    EV_STARTED        = 3'd0,
    EV_PAUSED         = 3'd1,
    EV_PAUSE_REJECTED = 3'd2,
    EV_RESUMED        = 3'd3,
    EV_RESUME_IGNORED = 3'd4,
    EV_UNKNOWN        = 3'd5
  } event_e;

  typedef enum logic [1:0] {
    MODE_UNKNOWN = 2'd0,
    MODE_STARTED = 2'd1,
    MODE_PAUSED  = 2'd2,
    MODE_RESUMED = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    KW_NONE,
    KW_START,
    KW_PAUSE,
    KW_RESUME
  } kw_e;

  typedef struct packed {
    event_e ev;
    mode_e  mode;
  } verdict_t;

  function automatic byte_t upcase(byte_t c);
    return (c >= ChrLowA && c <= ChrLowZ) ? c - CaseDiff : c;
  endfunction

  function automatic logic is_blank(byte_t c);
    return (c == ChrSpace) || (c == ChrTab);
  endfunction

  function automatic logic is_eol(byte_t c);
    return (c == ChrCr) || (c == ChrLf);
  endfunction

  function automatic pos_t kw_len(kw_e kw);
    pos_t n;
    unique case (kw)
      KW_START, KW_PAUSE: n = 3'd5;
      KW_RESUME:          n = 3'd6;
      default:            n = 3'd0;
    endcase
    return n;
  endfunction

  // Upper-case keyword letter at position j
  function automatic byte_t kw_letter(kw_e kw, pos_t j);
    byte_t c;
    c = ChrNone;
    unique case (kw)
      KW_START: begin
        unique case (j)
          3'd0:    c = "S";
          3'd1:    c = "T";
          3'd2:    c = "A";
          3'd3:    c = "R";
          3'd4:    c = "T";
          default: c = ChrNone;
        endcase
      end
      KW_PAUSE: begin
        unique case (j)
          3'd0:    c = "P";
          3'd1:    c = "A";
          3'd2:    c = "U";
          3'd3:    c = "S";
          3'd4:    c = "E";
          default: c = ChrNone;
        endcase
      end
      KW_RESUME: begin
        unique case (j)
          3'd0:    c = "R";
          3'd1:    c = "E";
          3'd2:    c = "S";
          3'd3:    c = "U";
          3'd4:    c = "M";
          3'd5:    c = "E";
          default: c = ChrNone;
        endcase
      end
      default: c = ChrNone;
    endcase
    return c;
  endfunction

  // Character at position j still extends a keyword prefix
  function automatic logic kw_hit(kw_e kw, pos_t j, byte_t c);
    return (j < kw_len(kw)) && (upcase(c) == kw_letter(kw, j));
  endfunction

  // Character j after the first non-blank still fits a trimmed keyword:
  // inside the word it must match, past the word only trailing blanks are allowed
  function automatic logic kw_scan_ok(kw_e kw, pos_t j, byte_t c);
    return (j < kw_len(kw)) ? (upcase(c) == kw_letter(kw, j)) : is_blank(c);
  endfunction

  // Run mode transition for a completed line
  function automatic verdict_t decide(kw_e kw, mode_e mode);
    verdict_t v;
    v.ev   = EV_UNKNOWN;
    v.mode = MODE_UNKNOWN;
    unique case (kw)
      KW_START: begin
        v.ev   = EV_STARTED;
        v.mode = MODE_STARTED;
      end
      KW_PAUSE: begin
        if (mode == MODE_STARTED || mode == MODE_RESUMED) begin
          v.ev   = EV_PAUSED;
          v.mode = MODE_PAUSED;
        end else begin
          v.ev   = EV_PAUSE_REJECTED;
          v.mode = mode;
        end
      end
      KW_RESUME: begin
        if (mode == MODE_PAUSED) begin
          v.ev   = EV_RESUMED;
          v.mode = MODE_RESUMED;
        end else begin
          v.ev   = EV_RESUME_IGNORED;
          v.mode = mode;
        end
      end
      default: begin
        v.ev   = EV_UNKNOWN;
        v.mode = MODE_UNKNOWN;
      end
    endcase
    return v;
  endfunction

endpackage

[design/ukcd_if.sv]
// Valid/ready channel interfaces for received bytes and command events.
interface ukcd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface ukcd_evt_if;
  logic       valid;
  logic       ready;
  logic [2:0] event_code;
  logic [1:0] run_mode;
  logic       reporting_enabled;

  modport source (output valid, output event_code, output run_mode,
                  output reporting_enabled, input ready);
  modport sink   (input valid, input event_code, input run_mode,
                  input reporting_enabled, output ready);
endinterface

[design/uart_keyword_command_decoder.sv]
// Keyword command decoder: gathers received bytes into lines and drives a run mode.
//
// rx_i takes one received byte per word; evt_o gives one word per completed line
// (event code, run mode after the line, reporting flag). Both are valid/ready.
// Characters are kept in a 64-entry line memory with a registered read port.
// After an ordinary byte the next one can follow unless evt_o stalls. A byte that
// completes START, PAUSE or RESUME early is decided in that same cycle from running
// prefix flags, and the word appears on evt_o the next cycle. A CR or LF that closes
// a non-empty line starts a scan that reads the line memory one entry per cycle
// through its single read port, trimming and matching on the fly.
// rx_i.ready is low during a scan and its evaluation and while a finished word waits on evt_o and
// cannot be replaced in the same cycle; a stalled receiver thus holds the input
// side too, and no word is dropped.
// Reset empties the line, leaves discard mode and sets the mode to unknown.
// The line memory needs no clearing: only entries below the length are read.
module uart_keyword_command_decoder (
  input  logic               clk_i,
  input  logic               rst_ni,
  ukcd_byte_if.sink          rx_i,
  ukcd_evt_if.source         evt_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_EVAL
  } state_e;

  state_e                   state_q;
  ukcd_pkg::len_t           len_q;
  logic                     disc_q;
  ukcd_pkg::mode_e          mode_q;
  logic                     pf_start_q, pf_pause_q, pf_resume_q;
  ukcd_pkg::len_t           idx_q;
  logic                     rd_vld_q;
  logic                     seen_q;
  ukcd_pkg::pos_t           cnt_q;
  logic                     sm_start_q, sm_pause_q, sm_resume_q;
  logic                     out_vld_q;
  ukcd_pkg::verdict_t       out_q;

  ukcd_pkg::byte_t          mem_q [ukcd_pkg::LineCap];
  ukcd_pkg::byte_t          rdata_q;

  logic                     out_free;
  logic                     accept;
  ukcd_pkg::byte_t          ch;
  logic                     ch_eol;
  logic                     store_ok;
  ukcd_pkg::len_t           new_len;
  ukcd_pkg::pos_t           pos;
  logic                     pf_start_n, pf_pause_n, pf_resume_n;
  ukcd_pkg::kw_e            early_kw;
  ukcd_pkg::verdict_t       early_v;
  logic                     wr_en;
  logic                     rd_en;
  logic                     scan_take;
  ukcd_pkg::kw_e            scan_kw;
  ukcd_pkg::verdict_t       scan_v;
  logic                     out_set;

  // Handshake
  assign out_free   = !out_vld_q || evt_o.ready;
  assign rx_i.ready = (state_q == S_IDLE) && out_free;
  assign accept     = rx_i.valid && rx_i.ready;
  assign ch         = rx_i.rx_byte;
  assign ch_eol     = ukcd_pkg::is_eol(ch);

  // Store path and running keyword prefix flags
  assign store_ok = len_q < ukcd_pkg::len_t'(ukcd_pkg::LineCap - 1);
  assign new_len  = len_q + ukcd_pkg::len_t'(1);
  assign pos      = (len_q > ukcd_pkg::len_t'(7)) ? 3'd7 : len_q[2:0];

  assign pf_start_n  = pf_start_q  && ukcd_pkg::kw_hit(ukcd_pkg::KW_START,  pos, ch);
  assign pf_pause_n  = pf_pause_q  && ukcd_pkg::kw_hit(ukcd_pkg::KW_PAUSE,  pos, ch);
  assign pf_resume_n = pf_resume_q && ukcd_pkg::kw_hit(ukcd_pkg::KW_RESUME, pos, ch);

  always_comb begin
    early_kw = ukcd_pkg::KW_NONE;
    if (new_len == ukcd_pkg::len_t'(5) && pf_start_n) begin
      early_kw = ukcd_pkg::KW_START;
    end else if (new_len == ukcd_pkg::len_t'(5) && pf_pause_n) begin
      early_kw = ukcd_pkg::KW_PAUSE;
    end else if (new_len == ukcd_pkg::len_t'(6) && pf_resume_n) begin
      early_kw = ukcd_pkg::KW_RESUME;
    end
  end

  assign early_v = ukcd_pkg::decide(early_kw, mode_q);
  assign wr_en   = accept && !ch_eol && !disc_q && store_ok;

  // A new output word comes from an early keyword or from the end of a scan
  assign out_set = (wr_en && early_kw != ukcd_pkg::KW_NONE)
                || (state_q == S_EVAL && out_free);

  // Scan path: trim leading blanks, then match each keyword position by position
  assign rd_en     = (state_q == S_SCAN) && (idx_q != len_q);
  assign scan_take = rd_vld_q && (seen_q || !ukcd_pkg::is_blank(rdata_q));

  always_comb begin
    scan_kw = ukcd_pkg::KW_NONE;
    if (sm_start_q && cnt_q >= ukcd_pkg::kw_len(ukcd_pkg::KW_START)) begin
      scan_kw = ukcd_pkg::KW_START;
    end else if (sm_pause_q && cnt_q >= ukcd_pkg::kw_len(ukcd_pkg::KW_PAUSE)) begin
      scan_kw = ukcd_pkg::KW_PAUSE;
    end else if (sm_resume_q && cnt_q >= ukcd_pkg::kw_len(ukcd_pkg::KW_RESUME)) begin
      scan_kw = ukcd_pkg::KW_RESUME;
    end
  end

  assign scan_v = ukcd_pkg::decide(scan_kw, mode_q);

  // Line memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[len_q] <= ch;
    end
    if (rd_en) begin
      rdata_q <= mem_q[idx_q];
    end
  end

  // Control state and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      len_q       <= '0;
      disc_q      <= 1'b0;
      mode_q      <= ukcd_pkg::MODE_UNKNOWN;
      pf_start_q  <= 1'b1;
      pf_pause_q  <= 1'b1;
      pf_resume_q <= 1'b1;
      idx_q       <= '0;
      rd_vld_q    <= 1'b0;
      seen_q      <= 1'b0;
      cnt_q       <= '0;
      sm_start_q  <= 1'b1;
      sm_pause_q  <= 1'b1;
      sm_resume_q <= 1'b1;
      out_vld_q   <= 1'b0;
      out_q       <= '{ev: ukcd_pkg::EV_UNKNOWN, mode: ukcd_pkg::MODE_UNKNOWN};
    end else begin
      if (out_set) begin
        out_vld_q <= 1'b1;
      end else if (evt_o.ready) begin
        out_vld_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            if (ch_eol) begin
              if (disc_q) begin
                disc_q      <= 1'b0;
                len_q       <= '0;
                pf_start_q  <= 1'b1;
                pf_pause_q  <= 1'b1;
                pf_resume_q <= 1'b1;
              end else if (len_q != '0) begin
                state_q     <= S_SCAN;
                idx_q       <= '0;
                rd_vld_q    <= 1'b0;
                seen_q      <= 1'b0;
                cnt_q       <= '0;
                sm_start_q  <= 1'b1;
                sm_pause_q  <= 1'b1;
                sm_resume_q <= 1'b1;
              end
            end else if (!disc_q) begin
              if (store_ok) begin
                if (early_kw != ukcd_pkg::KW_NONE) begin
                  // buffer is exactly a keyword: complete without a line end
                  out_q       <= early_v;
                  mode_q      <= early_v.mode;
                  len_q       <= '0;
                  pf_start_q  <= 1'b1;
                  pf_pause_q  <= 1'b1;
                  pf_resume_q <= 1'b1;
                end else begin
                  len_q       <= new_len;
                  pf_start_q  <= pf_start_n;
                  pf_pause_q  <= pf_pause_n;
                  pf_resume_q <= pf_resume_n;
                end
              end else begin
                // overlong line: drop it up to the next line end
                disc_q      <= 1'b1;
                len_q       <= '0;
                pf_start_q  <= 1'b1;
                pf_pause_q  <= 1'b1;
                pf_resume_q <= 1'b1;
              end
            end
          end
        end
        S_SCAN: begin
          rd_vld_q <= rd_en;
          if (rd_en) begin
            idx_q <= idx_q + ukcd_pkg::len_t'(1);
          end
          if (scan_take) begin
            seen_q      <= 1'b1;
            cnt_q       <= (cnt_q == 3'd7) ? cnt_q : cnt_q + 3'd1;
            sm_start_q  <= sm_start_q &&
                           ukcd_pkg::kw_scan_ok(ukcd_pkg::KW_START, cnt_q, rdata_q);
            sm_pause_q  <= sm_pause_q &&
                           ukcd_pkg::kw_scan_ok(ukcd_pkg::KW_PAUSE, cnt_q, rdata_q);
            sm_resume_q <= sm_resume_q &&
                           ukcd_pkg::kw_scan_ok(ukcd_pkg::KW_RESUME, cnt_q, rdata_q);
          end
          if (!rd_en && !rd_vld_q) begin
            state_q <= S_EVAL;
          end
        end
        S_EVAL: begin
          if (out_free) begin
            out_q       <= scan_v;
            mode_q      <= scan_v.mode;
            len_q       <= '0;
            pf_start_q  <= 1'b1;
            pf_pause_q  <= 1'b1;
            pf_resume_q <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  // Output word
  assign evt_o.valid             = out_vld_q;
  assign evt_o.event_code        = 3'(out_q.ev);
  assign evt_o.run_mode          = 2'(out_q.mode);
  assign evt_o.reporting_enabled = (out_q.mode != ukcd_pkg::MODE_PAUSED);

endmodule

[design/ukcd_checker.sv]
// Port-level checker for the keyword command decoder, bound to the top level.
`include "assert_macros.svh"

module ukcd_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       evt_valid_i,
  input logic       evt_ready_i,
  input logic [2:0] event_code_i,
  input logic [1:0] run_mode_i,
  input logic       reporting_enabled_i
);

  // Reporting flag follows the run mode
  `UKCD_ASSERT_IMPL(a_report_mode, clk_i, rst_ni, evt_valid_i, reporting_enabled_i == (run_mode_i != 2'(ukcd_pkg::MODE_PAUSED)))

  // Started, paused and unknown events report the matching mode
  `UKCD_ASSERT_IMPL(a_started_mode, clk_i, rst_ni, evt_valid_i && event_code_i == 3'(ukcd_pkg::EV_STARTED), run_mode_i == 2'(ukcd_pkg::MODE_STARTED))
  `UKCD_ASSERT_IMPL(a_paused_mode, clk_i, rst_ni, evt_valid_i && event_code_i == 3'(ukcd_pkg::EV_PAUSED), run_mode_i == 2'(ukcd_pkg::MODE_PAUSED))
  `UKCD_ASSERT_IMPL(a_unknown_mode, clk_i, rst_ni, evt_valid_i && event_code_i == 3'(ukcd_pkg::EV_UNKNOWN), run_mode_i == 2'(ukcd_pkg::MODE_UNKNOWN))

  // A stalled word holds
  `UKCD_ASSERT_NEXT(a_evt_hold, clk_i, rst_ni, evt_valid_i && !evt_ready_i, evt_valid_i && $stable(event_code_i) && $stable(run_mode_i))

endmodule

bind uart_keyword_command_decoder ukcd_checker u_ukcd_checker (
  .clk_i               (clk_i),
  .rst_ni              (rst_ni),
  .evt_valid_i         (evt_o.valid),
  .evt_ready_i         (evt_o.ready),
  .event_code_i        (evt_o.event_code),
  .run_mode_i          (evt_o.run_mode),
  .reporting_enabled_i (evt_o.reporting_enabled)
);
